// ===== design/pdt_pkg.sv =====
`default_nettype none

package pdt_pkg;

   localparam int MAX_POINTS = 256;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);

   localparam int CMD_W      = 2;
   localparam int COORD_W    = 32;
   localparam int DIFF_W     = COORD_W + 1;
   localparam int TOL_W      = 16;
   localparam int OI_W       = 8;
   localparam int MAP_W      = 8;
   localparam int OUT_IDX_W  = 8;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;

   localparam logic [CSR_IDX_W-1:0] CSR_IDX_TOL = '0;
   localparam logic [TOL_W-1:0]     TOL_RESET   = 16'd7;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD   = 2'd0,
      CMD_REMAP = 2'd1,
      CMD_START = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MAP_DATA,
      ST_DONE
   } state_type;

   // |a - b| < tol with an exact 33-bit difference
   function automatic logic near_axis(input logic [COORD_W-1:0] a,
                                      input logic [COORD_W-1:0] b,
                                      input logic [TOL_W-1:0]   tol);
      logic [DIFF_W-1:0] diff;
      logic [DIFF_W-1:0] mag;
      diff = {a[COORD_W-1], a} - {b[COORD_W-1], b};
      mag  = diff[DIFF_W-1] ? (~diff + DIFF_W'(1)) : diff;
      return mag < DIFF_W'(tol);
   endfunction

endpackage

`default_nettype wire

// ===== design/pdt_ram.sv =====
`default_nettype none

module pdt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== design/point_dedup_with_tolerance.sv =====
`default_nettype none

// Point welding with tolerance. An add transaction compares a signed Q16.16 point
// against the unique points stored so far, one stored point per cycle through a
// single compare unit fed by the coordinate memory's read port, and returns the
// first index whose x and y both lie strictly within match_tolerance, or appends
// the point and flags is_new. An add scans the stored points in order, stopping
// at the first match; an empty store appends at once, a full store fails at once.
// A remap does one index-map memory read; start and unknown commands go straight
// to ST_DONE. The block takes one transaction at a time; a waiting result does
// not hold off acceptance of the next one, but that one's result waits in ST_DONE
// until the output register is free. A full store or a remap of an index not yet
// written returns error with index 0. match_tolerance sits at byte address 0.
module point_dedup_with_tolerance
   import pdt_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         reset,

   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic        [CMD_W-1:0]      req_command,
   input  wire logic signed [COORD_W-1:0]    req_coord_x,
   input  wire logic signed [COORD_W-1:0]    req_coord_y,
   input  wire logic        [OI_W-1:0]       req_old_index,

   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic             [OUT_IDX_W-1:0]  rsp_unique_index,
   output logic                              rsp_is_new,
   output logic                              rsp_error,

   input  wire logic                         psel,
   input  wire logic                         penable,
   input  wire logic                         pwrite,
   input  wire logic        [CSR_ADDR_W-1:0] paddr,
   input  wire logic        [CSR_DATA_W-1:0] pwdata,
   output logic             [CSR_DATA_W-1:0] prdata,
   output logic                              pready
);

   localparam int OIW_W = CNT_W + OI_W;
   localparam int XY_W  = 2 * COORD_W;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     unique_count_ff, unique_count_in;
   logic [CNT_W-1:0]     points_seen_ff, points_seen_in;
   logic [TOL_W-1:0]     tol_ff, tol_in;
   logic [CNT_W-1:0]     scan_ff, scan_in;
   logic                 cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]     cmp_idx_ff, cmp_idx_in;
   logic [COORD_W-1:0]   px_ff, px_in;
   logic [COORD_W-1:0]   py_ff, py_in;
   logic [OUT_IDX_W-1:0] res_idx_ff, res_idx_in;
   logic                 res_new_ff, res_new_in;
   logic                 res_err_ff, res_err_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [OUT_IDX_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic                 rsp_new_ff, rsp_new_in;
   logic                 rsp_err_ff, rsp_err_in;

   logic                 xy_we;
   logic [IDX_W-1:0]     xy_waddr;
   logic [XY_W-1:0]      xy_wdata;
   logic [IDX_W-1:0]     xy_raddr;
   logic [XY_W-1:0]      xy_rdata;
   logic                 map_we;
   logic [IDX_W-1:0]     map_waddr;
   logic [MAP_W-1:0]     map_wdata;
   logic [IDX_W-1:0]     map_raddr;
   logic [MAP_W-1:0]     map_rdata;

   logic                 append;
   logic [COORD_W-1:0]   app_x, app_y;
   logic                 issue;
   logic                 match;
   logic                 full;
   logic [OIW_W-1:0]     oi_wide;
   logic                 csr_wr;

   pdt_ram #(.WIDTH(XY_W), .DEPTH(MAX_POINTS)) u_xy_ram (
      .clock (clock),
      .we    (xy_we),
      .waddr (xy_waddr),
      .wdata (xy_wdata),
      .raddr (xy_raddr),
      .rdata (xy_rdata)
   );

   pdt_ram #(.WIDTH(MAP_W), .DEPTH(MAX_POINTS)) u_map_ram (
      .clock (clock),
      .we    (map_we),
      .waddr (map_waddr),
      .wdata (map_wdata),
      .raddr (map_raddr),
      .rdata (map_rdata)
   );

   assign full    = (points_seen_ff == CNT_W'(MAX_POINTS));
   assign oi_wide = OIW_W'(req_old_index);
   assign issue   = (scan_ff < unique_count_ff);
   assign match   = near_axis(px_ff, xy_rdata[XY_W-1:COORD_W], tol_ff) &&
                    near_axis(py_ff, xy_rdata[COORD_W-1:0], tol_ff);

   assign csr_wr  = psel && penable && pwrite && pready;

   always_comb begin
      state_in        = state_ff;
      unique_count_in = unique_count_ff;
      points_seen_in  = points_seen_ff;
      scan_in         = scan_ff;
      cmp_vld_in      = 1'b0;
      cmp_idx_in      = cmp_idx_ff;
      px_in           = px_ff;
      py_in           = py_ff;
      res_idx_in      = res_idx_ff;
      res_new_in      = res_new_ff;
      res_err_in      = res_err_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_idx_in      = rsp_idx_ff;
      rsp_new_in      = rsp_new_ff;
      rsp_err_in      = rsp_err_ff;
      append          = 1'b0;
      app_x           = px_ff;
      app_y           = py_ff;
      xy_raddr        = scan_ff[IDX_W-1:0];
      map_raddr       = oi_wide[IDX_W-1:0];
      map_we          = 1'b0;
      map_waddr       = points_seen_ff[IDX_W-1:0];
      map_wdata       = MAP_W'(cmp_idx_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               res_idx_in = '0;
               res_new_in = 1'b0;
               res_err_in = 1'b0;
               state_in   = ST_DONE;
               case (req_command)
                  CMD_ADD: begin
                     if (full) begin
                        res_err_in = 1'b1;
                     end else if (unique_count_ff == '0) begin
                        append = 1'b1;
                        app_x  = req_coord_x;
                        app_y  = req_coord_y;
                     end else begin
                        px_in    = req_coord_x;
                        py_in    = req_coord_y;
                        scan_in  = '0;
                        state_in = ST_SCAN;
                     end
                  end
                  CMD_REMAP: begin
                     if (oi_wide < OIW_W'(points_seen_ff)) begin
                        state_in = ST_MAP_DATA;
                     end else begin
                        res_err_in = 1'b1;
                     end
                  end
                  CMD_START: begin
                     unique_count_in = '0;
                     points_seen_in  = '0;
                  end
                  default: begin
                     res_err_in = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // one read issued per cycle; the compare follows in the cycle after its read
            if (issue) begin
               scan_in    = scan_ff + CNT_W'(1);
               cmp_vld_in = 1'b1;
               cmp_idx_in = scan_ff[IDX_W-1:0];
            end
            if (cmp_vld_ff && match) begin
               map_we         = 1'b1;
               points_seen_in = points_seen_ff + CNT_W'(1);
               res_idx_in     = OUT_IDX_W'(cmp_idx_ff);
               cmp_vld_in     = 1'b0;
               state_in       = ST_DONE;
            end else if (cmp_vld_ff && !issue) begin
               append   = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_MAP_DATA: begin
            res_idx_in = OUT_IDX_W'(map_rdata);
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = res_idx_ff;
               rsp_new_in   = res_new_ff;
               rsp_err_in   = res_err_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (append) begin
         map_we          = 1'b1;
         map_wdata       = MAP_W'(unique_count_ff);
         unique_count_in = unique_count_ff + CNT_W'(1);
         points_seen_in  = points_seen_ff + CNT_W'(1);
         res_idx_in      = OUT_IDX_W'(unique_count_ff);
         res_new_in      = 1'b1;
         res_err_in      = 1'b0;
      end
   end

   assign xy_we    = append;
   assign xy_waddr = unique_count_ff[IDX_W-1:0];
   assign xy_wdata = {app_x, app_y};

   always_comb begin
      tol_in = tol_ff;
      if (csr_wr && paddr[CSR_ADDR_W-1:2] == CSR_IDX_TOL) begin
         tol_in = pwdata[TOL_W-1:0];
      end
   end

   always_comb begin
      unique case (paddr[CSR_ADDR_W-1:2])
         CSR_IDX_TOL: prdata = CSR_DATA_W'(tol_ff);
         default:     prdata = '0;
      endcase
   end

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         unique_count_ff <= '0;
         points_seen_ff  <= '0;
         tol_ff          <= TOL_RESET;
         cmp_vld_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         unique_count_ff <= unique_count_in;
         points_seen_ff  <= points_seen_in;
         tol_ff          <= tol_in;
         cmp_vld_ff      <= cmp_vld_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff    <= scan_in;
      cmp_idx_ff <= cmp_idx_in;
      px_ff      <= px_in;
      py_ff      <= py_in;
      res_idx_ff <= res_idx_in;
      res_new_ff <= res_new_in;
      res_err_ff <= res_err_in;
      rsp_idx_ff <= rsp_idx_in;
      rsp_new_ff <= rsp_new_in;
      rsp_err_ff <= rsp_err_in;
   end

   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_unique_index = rsp_idx_ff;
   assign rsp_is_new       = rsp_new_ff;
   assign rsp_error        = rsp_err_ff;

   a_count_order: assert property (@(posedge clock) disable iff (reset)
      unique_count_ff <= points_seen_ff)
      else $error("unique count exceeds points seen");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      points_seen_ff <= CNT_W'(MAX_POINTS))
      else $error("points seen exceeds store depth");

   a_cmp_in_range: assert property (@(posedge clock) disable iff (reset)
      cmp_vld_ff |-> (CNT_W'(cmp_idx_ff) < unique_count_ff))
      else $error("compare index beyond stored points");

   a_new_no_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_new_ff |-> !rsp_err_ff)
      else $error("new point flagged with error");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("transaction accepted while busy");

endmodule

`default_nettype wire

// ===== test/point_dedup_with_tolerance_tb.sv =====
`timescale 1ns / 100ps

module point_dedup_with_tolerance_tb;
   import pdt_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [OUT_IDX_W-1:0] idx;
      logic                 is_new;
      logic                 err;
   } weld_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                        req_valid     = 1'b0;
   logic                        req_ready;
   logic        [CMD_W-1:0]     req_command   = '0;
   logic signed [COORD_W-1:0]   req_coord_x   = '0;
   logic signed [COORD_W-1:0]   req_coord_y   = '0;
   logic        [OI_W-1:0]      req_old_index = '0;

   logic                        rsp_valid;
   logic                        rsp_ready     = 1'b0;
   logic        [OUT_IDX_W-1:0] rsp_unique_index;
   logic                        rsp_is_new;
   logic                        rsp_error;

   logic                        psel    = 1'b0;
   logic                        penable = 1'b0;
   logic                        pwrite  = 1'b0;
   logic       [CSR_ADDR_W-1:0] paddr   = '0;
   logic       [CSR_DATA_W-1:0] pwdata  = '0;
   logic       [CSR_DATA_W-1:0] prdata;
   logic                        pready;

   point_dedup_with_tolerance u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_coord_x      (req_coord_x),
      .req_coord_y      (req_coord_y),
      .req_old_index    (req_old_index),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_unique_index (rsp_unique_index),
      .rsp_is_new       (rsp_is_new),
      .rsp_error        (rsp_error),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // shadow of the welding state
   logic [TOL_W-1:0]   tol_now = TOL_RESET;
   logic [COORD_W-1:0] uniq_x [MAX_POINTS];
   logic [COORD_W-1:0] uniq_y [MAX_POINTS];
   logic [MAP_W-1:0]   weld_map [MAX_POINTS];
   int                 uniq_count = 0;
   int                 pts_seen   = 0;

   weld_rsp_type welds_due [$];

   int fails = 0;
   int n_add = 0, n_remap = 0, n_start = 0, n_unused = 0, n_tol = 0;

   bit send_idle_on = 1'b1;
   bit rcv_idle_on  = 1'b1;
   int rsp_hold     = 0;

   function automatic bit axis_close(input logic [COORD_W-1:0] a, input logic [COORD_W-1:0] b);
      longint gap;
      gap = longint'($signed(a)) - longint'($signed(b));
      if (gap < 0) gap = -gap;
      return gap < longint'(tol_now);
   endfunction

   function automatic weld_rsp_type compute_weld(input logic [CMD_W-1:0]   cmd,
                                                 input logic [COORD_W-1:0] x,
                                                 input logic [COORD_W-1:0] y,
                                                 input logic [OI_W-1:0]    oi);
      weld_rsp_type r;
      int           hit;
      r   = '0;
      hit = -1;
      case (cmd)
         CMD_ADD: begin
            if (pts_seen >= MAX_POINTS || uniq_count >= MAX_POINTS) begin
               r.err = 1'b1;
            end else begin
               for (int i = 0; i < uniq_count && hit < 0; i++)
                  if (axis_close(x, uniq_x[i]) && axis_close(y, uniq_y[i])) hit = i;
               if (hit < 0) begin
                  hit         = uniq_count;
                  uniq_x[hit] = x;
                  uniq_y[hit] = y;
                  uniq_count++;
                  r.is_new    = 1'b1;
               end
               weld_map[pts_seen] = hit[MAP_W-1:0];
               pts_seen++;
               r.idx = hit[OUT_IDX_W-1:0];
            end
         end
         CMD_REMAP: begin
            if (int'(oi) >= pts_seen) r.err = 1'b1;
            else r.idx = weld_map[oi];
         end
         CMD_START: begin
            uniq_count = 0;
            pts_seen   = 0;
         end
         default: r.err = 1'b1;
      endcase
      return r;
   endfunction

   function automatic logic [COORD_W-1:0] rand_coord();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return COORD_W'(int'($urandom_range(0, 200)) - 100);
         2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 50)
                                        : 32'h8000_0000 + $urandom_range(0, 50);
         default: return COORD_W'(int'($urandom_range(0, 2000000)) - 1000000);
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_tol();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return 65535;
         2: return $urandom_range(1, 16);
         3: return $urandom_range(1, 1000);
         default: return $urandom & 32'h0000_FFFF;
      endcase
   endfunction

   task automatic send_item(input logic [CMD_W-1:0]   cmd,
                            input logic [COORD_W-1:0] x,
                            input logic [COORD_W-1:0] y,
                            input logic [OI_W-1:0]    oi);
      int gap;
      gap = send_idle_on ? $urandom_range(0, 19) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_command   <= cmd;
      req_coord_x   <= x;
      req_coord_y   <= y;
      req_old_index <= oi;
      do @(posedge clock); while (!req_ready);
      welds_due.insert(welds_due.size(), compute_weld(cmd, x, y, oi));
      case (cmd)
         CMD_ADD:   n_add++;
         CMD_REMAP: n_remap++;
         CMD_START: n_start++;
         default:   n_unused++;
      endcase
   endtask

   // no transaction in flight, nothing outstanding
   task automatic drain_block();
      @(negedge clock);
      req_valid <= 1'b0;
      while (welds_due.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic csr_check_tol();
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {CSR_IDX_TOL, 2'b00};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== {{(CSR_DATA_W - TOL_W){1'b0}}, tol_now}) begin
         $error("match_tolerance: expected %0d, got %0d", tol_now, prdata);
         fails++;
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= val;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (idx == CSR_IDX_TOL) tol_now = val[TOL_W-1:0];
      n_tol++;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      csr_check_tol();
   endtask

   // receiver: random stall per transaction, or one long hold when asked
   initial begin
      int n;
      forever begin
         @(negedge clock);
         if (rsp_hold > 0) begin
            n        = rsp_hold;
            rsp_hold = 0;
         end else begin
            n = rcv_idle_on ? $urandom_range(0, 19) : 0;
         end
         if (n > 0) begin
            rsp_ready <= 1'b0;
            repeat (n) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin
      weld_rsp_type w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (welds_due.size() == 0) begin
            $error("result transaction with nothing outstanding: index %0d", rsp_unique_index);
            fails++;
         end else begin
            w = welds_due.pop_front();
            if (rsp_unique_index !== w.idx) begin
               $error("unique_index: expected %0d, got %0d", w.idx, rsp_unique_index);
               fails++;
            end
            if (rsp_is_new !== w.is_new) begin
               $error("is_new: expected %0d, got %0d", w.is_new, rsp_is_new);
               fails++;
            end
            if (rsp_error !== w.err) begin
               $error("error: expected %0d, got %0d", w.err, rsp_error);
               fails++;
            end
         end
      end
   end

   task automatic test_reset_tolerance();
      csr_check_tol();
   endtask

   task automatic test_directed();
      send_item(CMD_START, '0, '0, '0);
      send_item(CMD_REMAP, '0, '0, 8'd0);                   // empty map
      send_item(CMD_ADD, 32'd0, 32'd0, '0);
      send_item(CMD_ADD, 32'd6, 32'hFFFF_FFFA, '0);         // just inside
      send_item(CMD_ADD, 32'd7, 32'd0, '0);                 // bound is strict
      send_item(CMD_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0);
      send_item(CMD_ADD, 32'h8000_0000, 32'h8000_0000, '0); // no wrap on difference
      send_item(CMD_ADD, 32'h7FFF_FFFA, 32'h7FFF_FFF9, '0);
      send_item(CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
      send_item(CMD_ADD, 32'h8000_0006, 32'h8000_0000, '0);
      send_item(CMD_REMAP, '0, '0, 8'd1);
      send_item(CMD_REMAP, '0, '0, 8'd7);
      send_item(CMD_REMAP, '0, '0, 8'd8);                   // first unwritten
      send_item(CMD_REMAP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255);
      send_item(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
      send_item(CMD_REMAP, '0, '0, 8'd3);
      drain_block();
      csr_write(CSR_IDX_TOL, 32'd0);                         // nothing matches
      send_item(CMD_ADD, 32'd0, 32'd0, '0);
      drain_block();
      csr_write(CSR_IDX_TOL, 32'd65535);
      send_item(CMD_ADD, 32'd65534, 32'hFFFF_0002, '0);
      send_item(CMD_ADD, 32'd65535, 32'd0, '0);
      send_item(CMD_START, '0, '0, '0);
      send_item(CMD_REMAP, '0, '0, 8'd0);
   endtask

   task automatic test_store_full();
      drain_block();
      csr_write(CSR_IDX_TOL, 32'd0);
      send_item(CMD_START, '0, '0, '0);
      repeat (MAX_POINTS) send_item(CMD_ADD, $urandom, $urandom, OI_W'($urandom));
      send_item(CMD_ADD, $urandom, $urandom, '0);            // unique store full
      send_item(CMD_REMAP, '0, '0, 8'd255);
      send_item(CMD_REMAP, '0, '0, 8'd0);
      send_item(CMD_REMAP, '0, '0, 8'd128);
   endtask

   task automatic test_backpressure();
      drain_block();
      send_idle_on = 1'b0;
      rcv_idle_on  = 1'b0;
      rsp_hold     = 300;
      send_item(CMD_START, '0, '0, '0);
      repeat (24) begin
         if ($urandom_range(0, 3) == 0 && pts_seen > 0)
            send_item(CMD_REMAP, '0, '0, OI_W'($urandom_range(0, pts_seen - 1)));
         else
            send_item(CMD_ADD, COORD_W'(int'($urandom_range(0, 40)) - 20),
                      COORD_W'(int'($urandom_range(0, 40)) - 20), '0);
      end
   endtask

   task automatic test_random();
      int                 budget;
      int                 r;
      int                 k;
      int                 span;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      budget = 0;
      while (budget < 140) begin
         drain_block();
         send_idle_on = ($urandom_range(0, 3) != 0);
         rcv_idle_on  = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 2) != 0) csr_write(CSR_IDX_TOL, pick_tol());
         send_item(CMD_START, $urandom, $urandom, OI_W'($urandom));
         budget++;
         repeat ($urandom_range(5, 40)) begin
            r = $urandom_range(0, 99);
            if (r < 50 && uniq_count > 0) begin
               // land around a stored point, straddling the tolerance bound
               k    = $urandom_range(0, uniq_count - 1);
               span = int'(tol_now) + 2;
               x    = uniq_x[k] + COORD_W'(int'($urandom_range(0, 2 * span)) - span);
               y    = uniq_y[k] + COORD_W'(int'($urandom_range(0, 2 * span)) - span);
               send_item(CMD_ADD, x, y, OI_W'($urandom));
               budget++;
            end else if (r < 68) begin
               send_item(CMD_ADD, rand_coord(), rand_coord(), OI_W'($urandom));
               budget++;
            end else if (r < 88 && pts_seen > 0) begin
               send_item(CMD_REMAP, $urandom, $urandom, OI_W'($urandom_range(0, pts_seen - 1)));
               budget++;
            end else if (r < 94) begin
               send_item(CMD_REMAP, $urandom, $urandom, OI_W'($urandom_range(pts_seen, 255)));
               budget++;
            end else if (r < 97) begin
               send_item(CMD_UNUSED, $urandom, $urandom, OI_W'($urandom));
            end else begin
               send_item(CMD_START, $urandom, $urandom, OI_W'($urandom));
               budget++;
            end
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_tolerance();
      test_directed();
      test_store_full();
      test_backpressure();
      test_random();
      drain_block();
      $display("Covered %0d adds, %0d remaps, %0d starts, %0d unused commands",
               n_add, n_remap, n_start, n_unused);
      $display("across %0d tolerance writes, one full-store pass and one long output stall",
               n_tol);
      if (fails == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("status: fail");
      $finish;
   end

endmodule

// ===== sim.f =====
design/pdt_pkg.sv
design/pdt_ram.sv
design/point_dedup_with_tolerance.sv
test/point_dedup_with_tolerance_tb.sv
